@@ hdl/sts_pkg.sv @@
// ============================================================================
// sts_pkg
// shared types, constants and fixed-point helpers of the similarity solver
// ============================================================================
package sts_pkg;

    localparam int unsigned NumPointsDef = 5;
    localparam int unsigned CoordW       = 18;
    localparam int unsigned AccW         = 48;
    localparam int unsigned FxW          = 48;
    localparam int unsigned FloorW       = 16;
    localparam int unsigned OutW         = 32;
    localparam int unsigned InDataW      = 72;
    localparam int unsigned OutDataW     = 128;
    localparam int unsigned AddrW        = 1;

    localparam logic [AddrW-1:0] RegPivotFloor = 1'b0;
    localparam logic [FloorW-1:0] PivotFloorRst = 16'd1;

    localparam logic signed [FxW-1:0] Lim47 = 48'sh7FFF_FFFF_FFFF;

    typedef logic signed [FxW-1:0] fx_t;

    // one accepted point, as the front part hands it to the back part
    typedef struct packed {
        logic signed [CoordW-1:0] sx;
        logic signed [CoordW-1:0] sy;
        logic signed [CoordW-1:0] dx;
        logic signed [CoordW-1:0] dy;
        logic                     last_pt;
    } pt_req_t;

    typedef struct packed {
        logic                  solved;
        logic signed [OutW-1:0] a;
        logic signed [OutW-1:0] b;
        logic signed [OutW-1:0] tx;
        logic signed [OutW-1:0] ty;
    } res_t;

    function automatic fx_t clamp47(input logic signed [FxW+1:0] v);
        if (v > $signed({2'b00, Lim47}))       return Lim47;
        else if (v < -$signed({2'b00, Lim47})) return -Lim47;
        else                                   return v[FxW-1:0];
    endfunction

    function automatic logic [FxW-1:0] mag(input fx_t v);
        return v[FxW-1] ? FxW'(-v) : v;
    endfunction

    function automatic logic signed [OutW-1:0] sat32(input logic signed [FxW+8:0] v);
        if (v > 57'sd2147483647)       return 32'sh7FFF_FFFF;
        else if (v < -57'sd2147483648) return 32'sh8000_0000;
        else                           return v[OutW-1:0];
    endfunction

endpackage

@@ hdl/sts_front.sv @@
// ============================================================================
// sts_front
// takes points, counts them and marks the one that closes a frame
// ============================================================================
module sts_front #(
    parameter int unsigned NUM_POINTS = sts_pkg::NumPointsDef
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sts_pkg::InDataW-1:0] s_tdata,
    output logic                        q_valid,
    input  logic                        q_ready,
    output sts_pkg::pt_req_t            q_req
);
    logic [4:0] cnt_reg, cnt_next;
    logic       last;

    assign last     = (cnt_reg == 5'(NUM_POINTS - 1));
    assign s_tready = q_ready;
    assign q_valid  = s_tvalid;
    assign q_req.sx = s_tdata[17:0];
    assign q_req.sy = s_tdata[35:18];
    assign q_req.dx = s_tdata[53:36];
    assign q_req.dy = s_tdata[71:54];
    assign q_req.last_pt = last;

    always_comb begin
        cnt_next = cnt_reg;
        if (s_tvalid && q_ready) cnt_next = last ? 5'd0 : cnt_reg + 5'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) cnt_reg <= '0;
        else          cnt_reg <= cnt_next;
    end
endmodule

@@ hdl/sts_queue.sv @@
// ============================================================================
// sts_queue
// two-entry queue between the front and back parts
// ============================================================================
module sts_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sts_pkg::pt_req_t in_req,
    output logic             out_valid,
    input  logic             out_ready,
    output sts_pkg::pt_req_t out_req
);
    sts_pkg::pt_req_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_req;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

@@ hdl/sts_back.sv @@
// ============================================================================
// sts_back
// accumulates normal equations and solves them with a shared mul/div unit
// ============================================================================
module sts_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  sts_pkg::pt_req_t           in_req,
    input  logic [sts_pkg::FloorW-1:0] pivot_floor,
    output logic                       res_valid,
    input  logic                       res_ready,
    output sts_pkg::res_t              res
);
    typedef enum logic [3:0] {
        ST_ACC, ST_LOAD, ST_PIV, ST_SWAP, ST_FDIV, ST_ELIM, ST_BSUM, ST_BDIV,
        ST_MUL, ST_DIV, ST_PACK, ST_OUT
    } state_t;

    typedef logic signed [sts_pkg::AccW-1:0] acc_t;

    state_t             state_reg, ret_reg;
    acc_t               nm_reg [16];
    acc_t               rv_reg [4];
    sts_pkg::fx_t       m_reg [4][5];
    sts_pkg::fx_t       x_reg [4];
    sts_pkg::fx_t       f_reg, s_reg;
    logic [1:0]         i_reg, k_reg, p_reg;
    logic [2:0]         j_reg;
    logic               ok_reg;
    sts_pkg::res_t      res_reg;
    // shared multiply / divide unit
    logic [47:0]        ua_reg, ub_reg;
    logic               uneg_reg;
    logic [5:0]         ucnt_reg;
    logic [95:0]        prod_reg;
    logic [63:0]        num_reg;
    logic [47:0]        rem_reg;
    logic [63:0]        quo_reg;
    sts_pkg::fx_t       ures;

    // per-point products
    logic signed [35:0] sxx, syy, sxsy, sxdx, sydy, sydx, sxdy;

    assign sxx  = in_req.sx * in_req.sx;
    assign syy  = in_req.sy * in_req.sy;
    assign sxdx = in_req.sx * in_req.dx;
    assign sydy = in_req.sy * in_req.dy;
    assign sydx = in_req.sy * in_req.dx;
    assign sxdy = in_req.sx * in_req.dy;
    assign sxsy = '0;

    assign in_ready  = (state_reg == ST_ACC);
    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;

    function automatic sts_pkg::fx_t to_q16(input acc_t q8);
        if (q8 > 48'sd549755813887)       return sts_pkg::Lim47;
        else if (q8 < -48'sd549755813887) return -sts_pkg::Lim47;
        else                              return {q8[39:0], 8'd0};
    endfunction

    function automatic sts_pkg::fx_t sgn(input logic [63:0] m, input logic n);
        sts_pkg::fx_t r;
        r = (m > 64'(sts_pkg::Lim47)) ? sts_pkg::Lim47 : m[47:0];
        return n ? -r : r;
    endfunction

    function automatic sts_pkg::fx_t sub47(input sts_pkg::fx_t a, input sts_pkg::fx_t b);
        return sts_pkg::clamp47(50'(a) - 50'(b));
    endfunction

    // product result: truncate 16 fraction bits
    always_comb begin
        if (prod_reg[95:80] != 16'd0) ures = sgn(64'(sts_pkg::Lim47), uneg_reg);
        else                          ures = sgn(prod_reg[79:16], uneg_reg);
    end

    logic [48:0] trial;
    assign trial = {rem_reg, num_reg[63]} - {1'b0, ua_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            ret_reg   <= ST_ACC;
            for (int e = 0; e < 16; e++) nm_reg[e] <= '0;
            for (int e = 0; e < 4; e++)  rv_reg[e] <= '0;
        end else begin
            unique case (state_reg)
                ST_ACC: if (in_valid) begin
                    nm_reg[0]  <= nm_reg[0]  + 48'(sxx) + 48'(syy);
                    nm_reg[2]  <= nm_reg[2]  + 48'(in_req.sx) * 48'sd16;
                    nm_reg[3]  <= nm_reg[3]  + 48'(in_req.sy) * 48'sd16;
                    nm_reg[5]  <= nm_reg[5]  + 48'(syy) + 48'(sxx);
                    nm_reg[6]  <= nm_reg[6]  - 48'(in_req.sy) * 48'sd16;
                    nm_reg[7]  <= nm_reg[7]  + 48'(in_req.sx) * 48'sd16;
                    nm_reg[8]  <= nm_reg[8]  + 48'(in_req.sx) * 48'sd16;
                    nm_reg[9]  <= nm_reg[9]  - 48'(in_req.sy) * 48'sd16;
                    nm_reg[10] <= nm_reg[10] + 48'sd256;
                    nm_reg[12] <= nm_reg[12] + 48'(in_req.sy) * 48'sd16;
                    nm_reg[13] <= nm_reg[13] + 48'(in_req.sx) * 48'sd16;
                    nm_reg[15] <= nm_reg[15] + 48'sd256;
                    nm_reg[1]  <= nm_reg[1]  + 48'(sxsy);
                    nm_reg[4]  <= nm_reg[4]  + 48'(sxsy);
                    rv_reg[0]  <= rv_reg[0] + 48'(sxdx) + 48'(sydy);
                    rv_reg[1]  <= rv_reg[1] - 48'(sydx) + 48'(sxdy);
                    rv_reg[2]  <= rv_reg[2] + 48'(in_req.dx) * 48'sd16;
                    rv_reg[3]  <= rv_reg[3] + 48'(in_req.dy) * 48'sd16;
                    if (in_req.last_pt) state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    for (int r = 0; r < 4; r++) begin
                        for (int c = 0; c < 4; c++) m_reg[r][c] <= to_q16(nm_reg[r*4+c]);
                        m_reg[r][4] <= to_q16(rv_reg[r]);
                    end
                    for (int e = 0; e < 16; e++) nm_reg[e] <= '0;
                    for (int e = 0; e < 4; e++)  rv_reg[e] <= '0;
                    i_reg <= 2'd0; k_reg <= 2'd1; p_reg <= 2'd0;
                    ok_reg <= 1'b1;
                    state_reg <= ST_PIV;
                end
                // pivot search, one row per cycle
                ST_PIV: begin
                    if (k_reg > i_reg &&
                        sts_pkg::mag(m_reg[k_reg][i_reg]) > sts_pkg::mag(m_reg[p_reg][i_reg]))
                        p_reg <= k_reg;
                    if (k_reg == 2'd3 || i_reg == 2'd3) state_reg <= ST_SWAP;
                    else k_reg <= k_reg + 2'd1;
                end
                ST_SWAP: begin
                    if (m_reg[p_reg][i_reg] == '0 ||
                        sts_pkg::mag(m_reg[p_reg][i_reg]) < 48'(pivot_floor)) begin
                        ok_reg <= 1'b0;
                        state_reg <= ST_PACK;
                    end else begin
                        if (p_reg != i_reg) begin
                            for (int c = 0; c < 5; c++) begin
                                m_reg[i_reg][c] <= m_reg[p_reg][c];
                                m_reg[p_reg][c] <= m_reg[i_reg][c];
                            end
                        end
                        if (i_reg == 2'd3) begin
                            i_reg <= 2'd3; state_reg <= ST_BSUM;
                            s_reg <= m_reg[p_reg][4];
                            j_reg <= 3'd7;
                        end else begin
                            k_reg <= i_reg + 2'd1;
                            state_reg <= ST_FDIV;
                        end
                    end
                end
                ST_FDIV: begin
                    num_reg  <= {sts_pkg::mag(m_reg[k_reg][i_reg]), 16'd0};
                    ua_reg   <= sts_pkg::mag(m_reg[i_reg][i_reg]);
                    uneg_reg <= m_reg[k_reg][i_reg][47] ^ m_reg[i_reg][i_reg][47];
                    rem_reg <= '0; quo_reg <= '0; ucnt_reg <= 6'd0;
                    ret_reg <= ST_ELIM; j_reg <= {1'b0, i_reg};
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (!trial[48]) begin
                        rem_reg <= trial[47:0]; quo_reg <= {quo_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[46:0], num_reg[63]};
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    num_reg <= {num_reg[62:0], 1'b0};
                    ucnt_reg <= ucnt_reg + 6'd1;
                    if (ucnt_reg == 6'd63) begin
                        state_reg <= ret_reg;
                        if (ret_reg == ST_ELIM) begin
                            f_reg <= sgn(!trial[48] ? {quo_reg[62:0], 1'b1}
                                                    : {quo_reg[62:0], 1'b0}, uneg_reg);
                        end else begin
                            x_reg[i_reg] <= sgn(!trial[48] ? {quo_reg[62:0], 1'b1}
                                                           : {quo_reg[62:0], 1'b0}, uneg_reg);
                        end
                    end
                end
                // row update: one column per multiply
                ST_ELIM: begin
                    ua_reg   <= sts_pkg::mag(f_reg);
                    ub_reg   <= sts_pkg::mag(m_reg[i_reg][j_reg]);
                    prod_reg <= '0;
                    ucnt_reg <= 6'd0;
                    uneg_reg <= f_reg[47] ^ m_reg[i_reg][j_reg][47];
                    ret_reg  <= ST_ELIM;
                    state_reg <= ST_MUL;
                end
                // 48x16 slice per cycle, top slice first, then use the product
                ST_MUL: begin
                    if (ucnt_reg != 6'd3) begin
                        prod_reg <= {prod_reg[79:0], 16'd0} + 96'(ua_reg * ub_reg[47:32]);
                        ub_reg   <= {ub_reg[31:0], 16'd0};
                        ucnt_reg <= ucnt_reg + 6'd1;
                    end else if (ret_reg == ST_ELIM) begin
                        m_reg[k_reg][j_reg] <= sub47(m_reg[k_reg][j_reg], ures);
                        if (j_reg == 3'd4) begin
                            if (k_reg == 2'd3) begin
                                i_reg <= i_reg + 2'd1;
                                k_reg <= i_reg + 2'd2;
                                p_reg <= i_reg + 2'd1;
                                state_reg <= ST_PIV;
                            end else begin
                                k_reg <= k_reg + 2'd1;
                                state_reg <= ST_FDIV;
                            end
                        end else begin
                            j_reg <= j_reg + 3'd1;
                            state_reg <= ST_ELIM;
                        end
                    end else begin
                        s_reg <= sub47(s_reg, ures);
                        j_reg <= j_reg + 3'd1;
                        state_reg <= ST_BSUM;
                    end
                end
                // back substitution, j of 7 starts a row
                ST_BSUM: begin
                    if (j_reg == 3'd7) begin
                        j_reg <= {1'b0, i_reg} + 3'd1;
                        s_reg <= m_reg[i_reg][4];
                    end else if (j_reg <= 3'd3) begin
                        ua_reg   <= sts_pkg::mag(m_reg[i_reg][j_reg]);
                        ub_reg   <= sts_pkg::mag(x_reg[j_reg[1:0]]);
                        prod_reg <= '0;
                        ucnt_reg <= 6'd0;
                        uneg_reg <= m_reg[i_reg][j_reg][47] ^ x_reg[j_reg[1:0]][47];
                        ret_reg  <= ST_BSUM;
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_BDIV;
                    end
                end
                ST_BDIV: begin
                    num_reg  <= {sts_pkg::mag(s_reg), 16'd0};
                    ua_reg   <= sts_pkg::mag(m_reg[i_reg][i_reg]);
                    uneg_reg <= s_reg[47] ^ m_reg[i_reg][i_reg][47];
                    rem_reg <= '0; quo_reg <= '0; ucnt_reg <= 6'd0;
                    ret_reg <= (i_reg == 2'd0) ? ST_PACK : ST_BSUM;
                    state_reg <= ST_DIV;
                    if (i_reg != 2'd0) j_reg <= 3'd7;
                end
                ST_PACK: begin
                    if (ret_reg == ST_BSUM) begin
                        i_reg <= i_reg - 2'd1;
                    end
                    res_reg.solved <= ok_reg;
                    res_reg.a  <= ok_reg ? sts_pkg::sat32({x_reg[0][47], x_reg[0], 8'd0}) : '0;
                    res_reg.b  <= ok_reg ? sts_pkg::sat32({x_reg[1][47], x_reg[1], 8'd0}) : '0;
                    res_reg.tx <= ok_reg ? sts_pkg::sat32(57'(x_reg[2] / 48'sd16)) : '0;
                    res_reg.ty <= ok_reg ? sts_pkg::sat32(57'(x_reg[3] / 48'sd16)) : '0;
                    state_reg <= ST_OUT;
                end
                ST_OUT: if (res_ready) state_reg <= ST_ACC;
                default: state_reg <= ST_ACC;
            endcase
            // after a back division that returns to the sum, step to the row above
            if (state_reg == ST_DIV && ucnt_reg == 6'd63 && ret_reg == ST_BSUM)
                i_reg <= i_reg - 2'd1;
        end
    end
endmodule

@@ hdl/similarity_transform_solver_core.sv @@
// ============================================================================
// similarity_transform_solver_core
// least-squares 2-d similarity transform from a frame of point pairs
// ============================================================================
// channel   dir  handshake            content
// s_        in   s_tvalid/s_tready    one point pair per request
// m_        out  m_tvalid/m_tready    solved flag and a, b, tx, ty
// apb       in   psel/penable         pivot_floor at byte address 0
//
// the back part absorbs point requests while it accumulates; the last point
// of a frame starts a solve that runs on the shared bit-serial divider
// (10 quotients) and a sliced multiply per matrix column or
// back-substitution term. reset is synchronous on aresetn and clears
// accumulators and counters. the queue keeps taking points while a solve
// runs until it is full; a stalled result holds the back part.
module similarity_transform_solver_core #(
    parameter int unsigned NUM_POINTS = sts_pkg::NumPointsDef
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // src_x, src_y, dst_x, dst_y (18 bits each)
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // scale_cos, scale_sin, shift_x, shift_y
    output logic         m_tuser,   // solved
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [sts_pkg::FloorW-1:0] floor_reg;
    logic                       fq_valid, fq_ready, bq_valid, bq_ready;
    sts_pkg::pt_req_t           fq_req, bq_req;
    sts_pkg::res_t              res;

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {16'd0, floor_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) floor_reg <= sts_pkg::PivotFloorRst;
        else if (psel && penable && pwrite && paddr == 3'd0) floor_reg <= pwdata[15:0];
    end

    sts_front #(.NUM_POINTS(NUM_POINTS)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .q_valid(fq_valid), .q_ready(fq_ready), .q_req(fq_req)
    );

    sts_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fq_valid), .in_ready(fq_ready), .in_req(fq_req),
        .out_valid(bq_valid), .out_ready(bq_ready), .out_req(bq_req)
    );

    sts_back u_back (
        .aclk, .aresetn,
        .in_valid(bq_valid), .in_ready(bq_ready), .in_req(bq_req),
        .pivot_floor(floor_reg),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tuser = res.solved;
    assign m_tdata = {res.ty, res.tx, res.b, res.a};
endmodule

@@ tb/solver_checker.sv @@
// ============================================================================
// solver_checker
// watches both channels and the register port, predicts each transform and
// compares it field by field with what the solver returns
// ============================================================================
module solver_checker #(
    parameter int unsigned NUM_POINTS = sts_pkg::NumPointsDef
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [71:0]  s_tdata,   // src_x, src_y, dst_x, dst_y (18 bits each)
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,   // scale_cos, scale_sin, shift_x, shift_y
    input  logic         m_tuser,   // solved
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending,
    output int           result_count,
    output int           solved_count
);
    localparam longint Lim = 64'sh7FFF_FFFF_FFFF;

    longint         acc_mat[16];
    longint         acc_rhs[4];
    int             pts_in_frame;
    logic [15:0]    floor_q;
    sts_pkg::res_t  transform_q[$];
    int             n_predicted;

    function automatic longint sat47(input longint v);
        if (v > Lim) return Lim;
        if (v < -Lim) return -Lim;
        return v;
    endfunction

    function automatic longint unsigned magn(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint from_mag(input longint unsigned m, input bit neg);
        longint r;
        r = (m > Lim) ? Lim : longint'(m);
        return neg ? -r : r;
    endfunction

    function automatic longint fx_times(input longint a, input longint b);
        logic [127:0] p;
        p = {64'd0, magn(a)} * {64'd0, magn(b)};
        if (p[127:80] != 0) return from_mag(Lim, (a < 0) != (b < 0));
        return from_mag(p[79:16], (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_quot(input longint num, input longint den);
        longint unsigned q;
        q = (magn(num) << 16) / magn(den);
        return from_mag(q, (num < 0) != (den < 0));
    endfunction

    function automatic longint widen_q8(input longint v);
        if (v > Lim / 256) return Lim;
        if (v < -(Lim / 256)) return -Lim;
        return sat47(v * 256);
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // gaussian elimination with partial pivoting on the accumulated system
    function automatic sts_pkg::res_t solve_transform();
        longint m[4][5];
        longint x[4];
        longint t, f, s;
        int     p;
        sts_pkg::res_t r;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) m[i][j] = widen_q8(acc_mat[i*4+j]);
            m[i][4] = widen_q8(acc_rhs[i]);
        end
        for (int i = 0; i < 4; i++) begin
            p = i;
            for (int k = i + 1; k < 4; k++)
                if (magn(m[k][i]) > magn(m[p][i])) p = k;
            // too small or zero pivot: all-zero failure result
            if (m[p][i] == 0 || magn(m[p][i]) < longint'(floor_q)) return r;
            if (p != i) begin
                for (int j = 0; j < 5; j++) begin
                    t = m[i][j]; m[i][j] = m[p][j]; m[p][j] = t;
                end
            end
            for (int k = i + 1; k < 4; k++) begin
                f = fx_quot(m[k][i], m[i][i]);
                for (int j = i; j < 5; j++) m[k][j] = sat47(m[k][j] - fx_times(f, m[i][j]));
            end
        end
        for (int i = 3; i >= 0; i--) begin
            s = m[i][4];
            for (int j = i + 1; j < 4; j++) s = sat47(s - fx_times(m[i][j], x[j]));
            x[i] = fx_quot(s, m[i][i]);
        end
        r.solved = 1'b1;
        r.a  = clip32(x[0] * 256);
        r.b  = clip32(x[1] * 256);
        r.tx = clip32(x[2] / 16);
        r.ty = clip32(x[3] / 16);
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch on %s at %0t: got %0d, want %0d", what, $time, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want) report(what, got, want);
    endtask

    assign pending = n_predicted - result_count;

    always @(posedge aclk) begin
        longint r1[4], r2[4], dx, dy;
        sts_pkg::res_t got, want;
        if (!aresetn) begin
            foreach (acc_mat[i]) acc_mat[i] = 0;
            foreach (acc_rhs[i]) acc_rhs[i] = 0;
            pts_in_frame = 0;
            floor_q = sts_pkg::PivotFloorRst;
            transform_q.delete();
            fail_count = 0;
            result_count = 0;
            solved_count = 0;
            n_predicted = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == sts_pkg::RegPivotFloor)
                floor_q = pwdata[15:0];
            if (s_tvalid && s_tready) begin
                r1[0] = $signed(s_tdata[17:0]);
                r1[1] = -longint'($signed(s_tdata[35:18]));
                r1[2] = 16; r1[3] = 0;
                r2[0] = $signed(s_tdata[35:18]);
                r2[1] = $signed(s_tdata[17:0]);
                r2[2] = 0;  r2[3] = 16;
                dx = $signed(s_tdata[53:36]);
                dy = $signed(s_tdata[71:54]);
                for (int j = 0; j < 4; j++) begin
                    for (int k = 0; k < 4; k++)
                        acc_mat[j*4+k] += r1[j] * r1[k] + r2[j] * r2[k];
                    acc_rhs[j] += r1[j] * dx + r2[j] * dy;
                end
                pts_in_frame = (pts_in_frame + 1) & 31;
                if (pts_in_frame >= NUM_POINTS) begin
                    transform_q = {transform_q, solve_transform()};
                    n_predicted++;
                    foreach (acc_mat[i]) acc_mat[i] = 0;
                    foreach (acc_rhs[i]) acc_rhs[i] = 0;
                    pts_in_frame = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96]};
                if (transform_q.size() == 0) begin
                    $display("unexpected transform at %0t", $time);
                    fail_count++;
                end else begin
                    want = transform_q.pop_front();
                    check_field("solved", got.solved, want.solved);
                    check_field("scale_cos", got.a, want.a);
                    check_field("scale_sin", got.b, want.b);
                    check_field("shift_x", got.tx, want.tx);
                    check_field("shift_y", got.ty, want.ty);
                end
                result_count++;
                if (got.solved) solved_count++;
            end
        end
    end

endmodule

@@ tb/tb.sv @@
// ============================================================================
// tb
// drives point frames and pivot floor settings into the solver and gives the
// verdict from the checker's failure count
// ============================================================================
module tb;
    localparam int NPTS      = sts_pkg::NumPointsDef;
    localparam int FRAMES    = 63;          // random frames per floor setting
    localparam int HOLD_LEN  = 3000;        // long result stall
    localparam int DOG_LIMIT = 20000;       // idle cycles before giving up

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count, pending, result_count, solved_count;
    int dog = 0;
    bit no_gaps;          // burst stretches with no sender idling
    int frames_sent;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    similarity_transform_solver_core #(.NUM_POINTS(NPTS)) uut (.*);

    solver_checker #(.NUM_POINTS(NPTS)) chk (.*);

    // watchdog: cycles in which no request moves on any port
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) dog <= 0;
        else dog <= dog + 1;
        if (dog >= DOG_LIMIT) begin
            $display("timeout with %0d transforms outstanding", pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold after the twentieth result
    initial begin
        int gap;
        int taken;
        taken = 0;
        @(posedge aresetn);
        forever begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
            // block fills up behind the stalled result while points keep coming
            if (taken == 20) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end
        end
    end

    // one point request, with a random gap in front of it unless no_gaps is set
    task automatic send_point(input logic [17:0] sx, input logic [17:0] sy,
                              input logic [17:0] dx, input logic [17:0] dy);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dy, dx, sy, sx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // setup then access phase of a register write
    task automatic write_floor(input logic [15:0] v);
        s_tvalid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sts_pkg::RegPivotFloor, 2'b00};
        pwdata  <= {16'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // let every outstanding transform arrive, then let the solver settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    function automatic logic [17:0] clip18(input longint v);
        if (v > 131071) return 18'h1FFFF;
        if (v < -131072) return 18'h20000;
        return v[17:0];
    endfunction

    // one frame: mostly a true similarity transform with noise,
    // sometimes raw random pairs, sometimes one repeated point
    task automatic send_frame();
        int     kind, span;
        longint a, b, tx, ty, sx, sy, dx, dy;
        logic [71:0] fixed_pt;
        kind = $urandom_range(0, 9);
        span = (1 << $urandom_range(4, 17)) - 1;
        a  = $signed($urandom_range(0, 1024)) - 512;
        b  = $signed($urandom_range(0, 1024)) - 512;
        tx = $signed($urandom_range(0, 8000)) - 4000;
        ty = $signed($urandom_range(0, 8000)) - 4000;
        fixed_pt = 72'({$urandom, $urandom, $urandom});
        for (int i = 0; i < NPTS; i++) begin
            if (kind < 7) begin
                sx = $signed($urandom_range(0, 2 * span)) - span;
                sy = $signed($urandom_range(0, 2 * span)) - span;
                dx = (a * sx - b * sy) / 256 + tx + $signed($urandom_range(0, 6)) - 3;
                dy = (b * sx + a * sy) / 256 + ty + $signed($urandom_range(0, 6)) - 3;
                send_point(clip18(sx), clip18(sy), clip18(dx), clip18(dy));
            end else if (kind < 9) begin
                send_point(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
            end else begin
                send_point(fixed_pt[17:0], fixed_pt[35:18], fixed_pt[53:36], fixed_pt[71:54]);
            end
        end
        frames_sent++;
    endtask

    initial begin
        logic [15:0] floors[5];
        logic [17:0] ext[4];
        floors = '{16'd0, 16'd65535, 16'd1, 16'd300, 16'd40000};
        ext    = '{18'h1FFFF, 18'h20000, 18'h00000, 18'h3FFFF};
        frames_sent = 0;
        no_gaps = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: all-zero frame fails on a zero pivot
        for (int i = 0; i < NPTS; i++) send_point('0, '0, '0, '0);
        // one repeated point: singular system
        for (int i = 0; i < NPTS; i++) send_point(18'd160, 18'd320, 18'd480, 18'd640);
        // identity on a small square plus one more point off the square
        send_point('0, '0, '0, '0);
        send_point(18'd160, '0, 18'd160, '0);
        send_point('0, 18'd160, '0, 18'd160);
        send_point(18'd160, 18'd160, 18'd160, 18'd160);
        send_point(18'h3FF60, 18'd80, 18'h3FF60, 18'd80);
        // field extremes, to push the solver into saturation
        for (int i = 0; i < NPTS; i++)
            send_point(ext[i % 4], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4]);
        send_frame();
        drain();

        // random frames under each floor setting, with bursts and drains
        foreach (floors[f]) begin
            write_floor(f == 3 ? 16'($urandom) : floors[f]);
            for (int n = 0; n < FRAMES; n++) begin
                no_gaps = (n % 16) >= 12;
                send_frame();
                // sender waits for every transform in the middle of a phase
                if (n == FRAMES / 2) drain();
            end
            no_gaps = 1'b0;
            drain();
        end

        $display("sent %0d point frames over %0d floor settings, long stall included",
                 frames_sent + 4, 6);
        $display("checked %0d transforms, %0d of them solved", result_count, solved_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
